@@ src/lpr_pkg.sv @@
`default_nettype none

package lpr_pkg;

    localparam int FRAMES = 8;
    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int RANK_W = IDX_W;
    localparam int PAGE_W = 16;
    localparam int CFG_W = 4;
    localparam int TOT_W = 32;
    localparam int OUT_IDX_W = 3;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 88;
    localparam int M_USED_W = 1 + OUT_IDX_W + 1 + PAGE_W + TOT_W + TOT_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(3);
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);
    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [TOT_W-1:0] tot_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

endpackage

`default_nettype wire

@@ src/lru_page_replacement.sv @@
// LRU page replacement unit.
// Page requests arrive on the s_ channel: s_tdata[15:0] is the page number and
// s_tdata[16] is the restart flag, which empties all frames and clears both
// totals before the request is handled. One result leaves on the m_ channel
// for every request: hit, frame index, eviction flag and page, and the
// saturating hit and fault totals. The cfg channel writes frame_count, the
// number of frames in use; it is always ready. It is to be written only
// while idle; the block itself does not enforce this. A request is taken
// while the sequencer is idle; the single shared page comparator and rank
// compare unit then walks the frames one by one, up to n, the active frame
// count (1 to 8), and an update step adjusts the ranks and loads the output
// register. s_tready is high only while the sequencer is idle, so a new
// request is not accepted until the previous one has finished its update.
// The result sits in an output register; the next request is accepted while it
// waits, but its own update holds until the receiver has taken the previous
// result. After reset all frames are empty, the totals are zero, frame_count
// is 3 and no result is pending.
`default_nettype none

module lru_page_replacement (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0: page[15:0], restart[16], zero fill.
    input  wire  [lpr_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    // Fields from bit 0: hit[0], frame_index[3:1], evicted_valid[4],
    // evicted_page[20:5], hit_total[52:21], fault_total[84:53], zero fill.
    output logic [lpr_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [lpr_pkg::CFG_W-1:0]     cfg_data
);

    lpr_pkg::state_t state_reg, state_next;
    logic [lpr_pkg::CFG_W-1:0] cfg_reg;

    lpr_pkg::page_t page_reg [lpr_pkg::FRAMES];
    lpr_pkg::page_t page_next [lpr_pkg::FRAMES];
    lpr_pkg::rank_t rank_reg [lpr_pkg::FRAMES];
    lpr_pkg::rank_t rank_next [lpr_pkg::FRAMES];
    logic [lpr_pkg::FRAMES-1:0] valid_reg, valid_next;
    lpr_pkg::tot_t hits_reg, hits_next;
    lpr_pkg::tot_t faults_reg, faults_next;

    lpr_pkg::page_t req_reg, req_next;
    lpr_pkg::cnt_t n_reg, n_next;
    lpr_pkg::idx_t idx_reg, idx_next;
    logic found_reg, found_next;
    lpr_pkg::idx_t hit_slot_reg, hit_slot_next;
    lpr_pkg::rank_t hit_rank_reg, hit_rank_next;
    logic empty_reg, empty_next;
    lpr_pkg::idx_t empty_slot_reg, empty_slot_next;
    lpr_pkg::idx_t old_slot_reg, old_slot_next;
    lpr_pkg::rank_t old_rank_reg, old_rank_next;
    lpr_pkg::page_t old_page_reg, old_page_next;

    logic m_valid_reg, m_valid_next;
    logic [lpr_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    lpr_pkg::cnt_t n_active;
    logic cur_valid, cur_match, last_scan, commit;
    lpr_pkg::page_t cur_page;
    lpr_pkg::rank_t cur_rank;
    lpr_pkg::idx_t slot;
    lpr_pkg::rank_t limit;
    logic age_all, ev_valid;
    lpr_pkg::page_t ev_page;
    lpr_pkg::tot_t hits_new, faults_new;

    assign s_tready = (state_reg == lpr_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

    always_comb begin
        if (cfg_reg == '0) begin
            n_active = lpr_pkg::CNT_W'(1);
        end else if (32'(cfg_reg) > 32'(lpr_pkg::FRAMES)) begin
            n_active = lpr_pkg::CNT_W'(lpr_pkg::FRAMES);
        end else begin
            n_active = lpr_pkg::CNT_W'(cfg_reg);
        end
    end

    assign cur_valid = valid_reg[idx_reg];
    assign cur_page = page_reg[idx_reg];
    assign cur_rank = rank_reg[idx_reg];
    assign cur_match = cur_valid && (cur_page == req_reg);
    assign last_scan = ((lpr_pkg::CNT_W'(idx_reg) + lpr_pkg::CNT_W'(1)) == n_reg);
    assign commit = !m_valid_reg || m_tready;

    always_comb begin
        if (found_reg) begin
            slot = hit_slot_reg;
            limit = hit_rank_reg;
            age_all = 1'b0;
            ev_valid = 1'b0;
            ev_page = '0;
        end else if (empty_reg) begin
            slot = empty_slot_reg;
            limit = '0;
            age_all = 1'b1;
            ev_valid = 1'b0;
            ev_page = '0;
        end else begin
            slot = old_slot_reg;
            limit = old_rank_reg;
            age_all = 1'b0;
            ev_valid = 1'b1;
            ev_page = old_page_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        page_next = page_reg;
        rank_next = rank_reg;
        valid_next = valid_reg;
        hits_next = hits_reg;
        faults_next = faults_reg;
        req_next = req_reg;
        n_next = n_reg;
        idx_next = idx_reg;
        found_next = found_reg;
        hit_slot_next = hit_slot_reg;
        hit_rank_next = hit_rank_reg;
        empty_next = empty_reg;
        empty_slot_next = empty_slot_reg;
        old_slot_next = old_slot_reg;
        old_rank_next = old_rank_reg;
        old_page_next = old_page_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next = m_data_reg;
        hits_new = (hits_reg == lpr_pkg::TOT_MAX) ? hits_reg : hits_reg + 1'b1;
        faults_new = (faults_reg == lpr_pkg::TOT_MAX) ? faults_reg : faults_reg + 1'b1;

        unique case (state_reg)
            lpr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    req_next = s_tdata[lpr_pkg::PAGE_W-1:0];
                    n_next = n_active;
                    idx_next = '0;
                    found_next = 1'b0;
                    empty_next = 1'b0;
                    if (s_tdata[lpr_pkg::PAGE_W]) begin
                        valid_next = '0;
                        hits_next = '0;
                        faults_next = '0;
                        for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
                            page_next[i] = '0;
                            rank_next[i] = '0;
                        end
                    end
                    state_next = lpr_pkg::ST_SCAN;
                end
            end
            lpr_pkg::ST_SCAN: begin
                if (!found_reg && cur_match) begin
                    found_next = 1'b1;
                    hit_slot_next = idx_reg;
                    hit_rank_next = cur_rank;
                end
                if (!empty_reg && !cur_valid) begin
                    empty_next = 1'b1;
                    empty_slot_next = idx_reg;
                end
                if (idx_reg == '0 || cur_rank > old_rank_reg) begin
                    old_slot_next = idx_reg;
                    old_rank_next = cur_rank;
                    old_page_next = cur_page;
                end
                if (last_scan) begin
                    state_next = lpr_pkg::ST_UPDATE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            lpr_pkg::ST_UPDATE: begin
                if (commit) begin
                    for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
                        if (valid_reg[i] && (lpr_pkg::CNT_W'(i) < n_reg)
                                && (age_all || rank_reg[i] < limit)
                                && rank_reg[i] != lpr_pkg::RANK_MAX) begin
                            rank_next[i] = rank_reg[i] + 1'b1;
                        end
                    end
                    rank_next[slot] = '0;
                    valid_next[slot] = 1'b1;
                    page_next[slot] = req_reg;
                    if (found_reg) begin
                        hits_next = hits_new;
                    end else begin
                        faults_next = faults_new;
                    end
                    m_valid_next = 1'b1;
                    m_data_next = {
                        (lpr_pkg::M_TDATA_W - lpr_pkg::M_USED_W)'(0),
                        found_reg ? faults_reg : faults_new,
                        found_reg ? hits_new : hits_reg,
                        ev_page,
                        ev_valid,
                        lpr_pkg::OUT_IDX_W'(slot),
                        found_reg
                    };
                    state_next = lpr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lpr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpr_pkg::ST_IDLE;
            cfg_reg <= lpr_pkg::CFG_RESET;
            valid_reg <= '0;
            hits_reg <= '0;
            faults_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                cfg_reg <= cfg_data;
            end
            valid_reg <= valid_next;
            hits_reg <= hits_next;
            faults_reg <= faults_next;
            m_valid_reg <= m_valid_next;
            rank_reg <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg <= page_next;
        req_reg <= req_next;
        n_reg <= n_next;
        idx_reg <= idx_next;
        found_reg <= found_next;
        hit_slot_reg <= hit_slot_next;
        hit_rank_reg <= hit_rank_next;
        empty_reg <= empty_next;
        empty_slot_reg <= empty_slot_next;
        old_slot_reg <= old_slot_next;
        old_rank_reg <= old_rank_next;
        old_page_reg <= old_page_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

@@ src/lpr_checker.sv @@
`default_nettype none

module lpr_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_tvalid,
    input wire                           s_tready,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [lpr_pkg::M_TDATA_W-1:0]  m_tdata
);

    // No result may be pending in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // The unit walks the frames after every accepted request.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while the frame search runs");

    // A stalled result keeps its contents.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // A hit never evicts a page, and the fill bits stay zero.
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!(m_tdata[0] && m_tdata[4])
            && m_tdata[lpr_pkg::M_TDATA_W-1:lpr_pkg::M_USED_W] == '0))
        else $error("malformed result");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

`default_nettype wire
